// ----- hdl/bmcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared types, codes and constants of the button click detector.
// ----------------------------------------------------------------------------
package bmcd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MsCfgW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MsCfgW-1:0] MinPressReset = 16'd50;
  localparam logic [MsCfgW-1:0] GapReset      = 16'd200;
  localparam logic [CountW-1:0] CountMax      = 8'hFF;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegAutoReset  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegReportMode = 8'd1;
  localparam logic [CfgIdxW-1:0] RegMinPress   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegGap        = 8'd3;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_MULTI  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    RPT_NONE     = 2'd0,
    RPT_DURATION = 2'd1,
    RPT_COUNT    = 2'd2,
    RPT_BOTH     = 2'd3
  } report_e;

  typedef struct packed {
    logic              auto_reset;
    report_e           report_mode;
    logic [MsCfgW-1:0] min_press_ms;
    logic [MsCfgW-1:0] gap_ms;
  } cfg_t;

  typedef struct packed {
    op_e              opcode;
    logic             button_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              is_pressed;
    event_e            event_kind;
    logic [CountW-1:0] click_count;
    logic [TimeW-1:0]  duration_ms;
    logic              report_valid;
  } result_t;

endpackage

// ----- hdl/bmcd_if.sv -----
// ----------------------------------------------------------------------------
// bmcd channel interfaces
// Valid/ready channels for sample items, results and register writes.
// ----------------------------------------------------------------------------
interface bmcd_item_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic                      button_level;
  logic [bmcd_pkg::TimeW-1:0] now_ms;

  modport source (output valid, opcode, button_level, now_ms, input ready);
  modport sink   (input valid, opcode, button_level, now_ms, output ready);
  modport mon    (input valid, ready, opcode, button_level, now_ms);
endinterface

interface bmcd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        is_pressed;
  logic [1:0]                  event_kind;
  logic [bmcd_pkg::CountW-1:0] click_count;
  logic [bmcd_pkg::TimeW-1:0]  duration_ms;
  logic                        report_valid;

  modport source (output valid, is_pressed, event_kind, click_count, duration_ms,
                  report_valid, input ready);
  modport sink   (input valid, is_pressed, event_kind, click_count, duration_ms,
                  report_valid, output ready);
  modport mon    (input valid, ready, is_pressed, event_kind, click_count,
                  duration_ms, report_valid);
endinterface

interface bmcd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmcd_pkg::CfgIdxW-1:0]  index;
  logic [bmcd_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

// ----- hdl/bmcd_cfg.sv -----
// ----------------------------------------------------------------------------
// bmcd_cfg
// Configuration register bank, written over the register write channel.
// ----------------------------------------------------------------------------
module bmcd_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  logic [7:0]     wr_idx_i,
  input  logic [15:0]    wr_data_i,
  output bmcd_pkg::cfg_t cfg_o
);
  import bmcd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        RegAutoReset:  cfg_d.auto_reset   = wr_data_i[0];
        RegReportMode: cfg_d.report_mode  = report_e'(wr_data_i[1:0]);
        RegMinPress:   cfg_d.min_press_ms = wr_data_i[MsCfgW-1:0];
        RegGap:        cfg_d.gap_ms       = wr_data_i[MsCfgW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_reset   <= 1'b0;
      cfg_q.report_mode  <= RPT_NONE;
      cfg_q.min_press_ms <= MinPressReset;
      cfg_q.gap_ms       <= GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/bmcd_core.sv -----
// ----------------------------------------------------------------------------
// bmcd_core
// Detection state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module bmcd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bmcd_pkg::item_t   item_i,
  input  bmcd_pkg::cfg_t    cfg_i,
  output bmcd_pkg::result_t result_o
);
  import bmcd_pkg::*;

  logic              held_q, held_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  rel_q, rel_d;
  logic [TimeW-1:0]  dur_q, dur_d;
  logic [CountW-1:0] clicks_q, clicks_d;
  event_e            pend_q, pend_d;

  // state after sampling the button
  logic              s_held;
  logic [TimeW-1:0]  s_start, s_rel, s_dur;
  logic [CountW-1:0] s_clicks;
  event_e            s_pend;
  logic [TimeW-1:0]  press_len;
  logic [TimeW-1:0]  gap_limit;
  logic              decide;
  logic              rpt_on;

  assign rpt_on    = (cfg_i.report_mode != RPT_NONE);
  assign press_len = item_i.now_ms - start_q;

  always_comb begin
    s_held   = held_q;
    s_start  = start_q;
    s_rel    = rel_q;
    s_dur    = dur_q;
    s_clicks = clicks_q;
    s_pend   = pend_q;
    if (!item_i.button_level && !held_q) begin
      s_start = item_i.now_ms;
      s_held  = 1'b1;
    end else if (item_i.button_level && held_q) begin
      s_rel  = item_i.now_ms;
      s_held = 1'b0;
      if (press_len > {{(TimeW-MsCfgW){1'b0}}, cfg_i.min_press_ms}) begin
        s_dur = press_len;
        if (clicks_q != CountMax) begin
          s_clicks = clicks_q + CountW'(1);
        end
      end
    end
    // gap end taken from the release time after this sample, wrapping before the compare
    gap_limit = s_rel + {{(TimeW-MsCfgW){1'b0}}, cfg_i.gap_ms};
    decide = !s_held && (s_clicks != '0) && (gap_limit < item_i.now_ms);
    if (decide) begin
      s_pend = (s_clicks == CountW'(1)) ? EV_SINGLE : EV_MULTI;
    end
  end

  always_comb begin
    held_d   = held_q;
    start_d  = start_q;
    rel_d    = rel_q;
    dur_d    = dur_q;
    clicks_d = clicks_q;
    pend_d   = pend_q;
    result_o = '0;
    if (item_i.opcode == OP_CLEAR) begin
      held_d   = 1'b0;
      start_d  = '0;
      rel_d    = '0;
      dur_d    = '0;
      clicks_d = '0;
      pend_d   = EV_NONE;
    end else if ((pend_q != EV_NONE) && rpt_on) begin
      // standing event is reported instead of sampling
      result_o.is_pressed   = cfg_i.auto_reset ? 1'b0 : held_q;
      result_o.event_kind   = pend_q;
      result_o.click_count  = clicks_q;
      result_o.duration_ms  = dur_q;
      result_o.report_valid = 1'b1;
      if (cfg_i.auto_reset) begin
        held_d   = 1'b0;
        start_d  = '0;
        rel_d    = '0;
        dur_d    = '0;
        clicks_d = '0;
        pend_d   = EV_NONE;
      end
    end else begin
      held_d   = s_held;
      start_d  = s_start;
      rel_d    = s_rel;
      dur_d    = s_dur;
      clicks_d = s_clicks;
      pend_d   = s_pend;
      result_o.is_pressed   = s_held;
      result_o.event_kind   = s_pend;
      result_o.click_count  = s_clicks;
      result_o.duration_ms  = s_dur;
      result_o.report_valid = decide && rpt_on;
      if (decide && rpt_on && cfg_i.auto_reset) begin
        held_d   = 1'b0;
        start_d  = '0;
        rel_d    = '0;
        dur_d    = '0;
        clicks_d = '0;
        pend_d   = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      start_q  <= '0;
      rel_q    <= '0;
      dur_q    <= '0;
      clicks_q <= '0;
      pend_q   <= EV_NONE;
    end else if (step_i) begin
      held_q   <= held_d;
      start_q  <= start_d;
      rel_q    <= rel_d;
      dur_q    <= dur_d;
      clicks_q <= clicks_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ----- hdl/button_multi_click_detector_unit.sv -----
// ----------------------------------------------------------------------------
// button_multi_click_detector_unit
// Click and multi-click detection on timestamped active-low button samples.
// ----------------------------------------------------------------------------
// channel   dir  handshake    payload
// item_i    in   valid/ready  opcode, button_level, now_ms
// result_o  out  valid/ready  is_pressed, event_kind, click_count, duration_ms,
//                             report_valid
// cfg_i     in   valid/ready  index, data (always ready)
//
// One item per cycle sustained while the result is not stalled.
// Items pass an input register, the state update, then the result register.
// A stalled result holds the result register and, behind it, the input register.
// Reset clears the detection state and loads the register defaults.
// ----------------------------------------------------------------------------
module button_multi_click_detector_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bmcd_item_if.sink     item_i,
  bmcd_result_if.source result_o,
  bmcd_cfg_if.sink      cfg_i
);
  import bmcd_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;
  logic    step;

  assign advance      = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  bmcd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid && cfg_i.ready),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  bmcd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.opcode       <= op_e'(item_i.opcode);
      item_q.button_level <= item_i.button_level;
      item_q.now_ms       <= item_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.is_pressed   = res_q.is_pressed;
  assign result_o.event_kind   = res_q.event_kind;
  assign result_o.click_count  = res_q.click_count;
  assign result_o.duration_ms  = res_q.duration_ms;
  assign result_o.report_valid = res_q.report_valid;

endmodule

// ----- hdl/bmcd_checker.sv -----
// ----------------------------------------------------------------------------
// bmcd_checker
// Port-level checks on the click detector, bound to the top level.
// ----------------------------------------------------------------------------
module bmcd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        res_pressed_i,
  input logic [1:0]                  res_event_i,
  input logic [bmcd_pkg::CountW-1:0] res_count_i,
  input logic [bmcd_pkg::TimeW-1:0]  res_duration_i,
  input logic                        res_report_i
);
  import bmcd_pkg::*;

  // a report always carries a decided event
  a_report_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_report_i |-> res_event_i != EV_NONE)
    else $error("report without an event");

  // an event is only decided once a click has been counted
  a_event_has_clicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_event_i != EV_NONE) |-> res_count_i != '0)
    else $error("event with zero clicks");

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> (res_valid_i !== 1'b1))
    else $error("result valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transfer");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(res_event_i) && $stable(res_count_i)
      && $stable(res_duration_i) && $stable(res_report_i)
      && $stable(res_pressed_i))
    else $error("stalled result changed");

endmodule

bind button_multi_click_detector_unit bmcd_checker u_bmcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .res_pressed_i  (result_o.is_pressed),
  .res_event_i    (result_o.event_kind),
  .res_count_i    (result_o.click_count),
  .res_duration_i (result_o.duration_ms),
  .res_report_i   (result_o.report_valid)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click detector. A scoreboard object keeps
// its own copy of the detection state and registers, predicts the result of
// every accepted item and checks results in order. Stimulus is a short
// directed run, then random click bursts with noise and clears under several
// register settings, idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
import bmcd_pkg::*;

class click_scoreboard;
  cfg_t              cfg = '{auto_reset: 1'b0, report_mode: RPT_NONE,
                             min_press_ms: MinPressReset, gap_ms: GapReset};
  logic              held        = 1'b0;
  logic [TimeW-1:0]  press_start = '0;
  logic [TimeW-1:0]  release_at  = '0;
  logic [TimeW-1:0]  last_len    = '0;
  logic [CountW-1:0] clicks      = '0;
  event_e            pending     = EV_NONE;
  result_t           due_results[$];
  int unsigned       failures    = 0;

  function void clear_detection();
    held        = 1'b0;
    press_start = '0;
    release_at  = '0;
    last_len    = '0;
    clicks      = '0;
    pending     = EV_NONE;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      RegAutoReset:  cfg.auto_reset   = val[0];
      RegReportMode: cfg.report_mode  = report_e'(val[1:0]);
      RegMinPress:   cfg.min_press_ms = val;
      RegGap:        cfg.gap_ms       = val;
      default: ;
    endcase
  endfunction

  function result_t snapshot();
    result_t r;
    r.is_pressed   = held;
    r.event_kind   = pending;
    r.click_count  = clicks;
    r.duration_ms  = last_len;
    r.report_valid = 1'b0;
    return r;
  endfunction

  // values are taken before the auto reset, the held flag after it
  function result_t take_report();
    result_t r;
    r.event_kind   = pending;
    r.click_count  = clicks;
    r.duration_ms  = last_len;
    r.report_valid = 1'b1;
    if (cfg.auto_reset) clear_detection();
    r.is_pressed = held;
    return r;
  endfunction

  function result_t predict_click_result(item_t it);
    logic [TimeW-1:0] press_len;
    logic [TimeW-1:0] gap_end;
    if (it.opcode == OP_CLEAR) begin
      clear_detection();
      return snapshot();
    end
    if (pending != EV_NONE && cfg.report_mode != RPT_NONE) return take_report();
    if (!it.button_level && !held) begin
      press_start = it.now_ms;
      held        = 1'b1;
    end else if (it.button_level && held) begin
      press_len  = it.now_ms - press_start;
      release_at = it.now_ms;
      held       = 1'b0;
      if (press_len > {16'h0, cfg.min_press_ms}) begin
        last_len = press_len;
        if (clicks != CountMax) clicks = clicks + 1'b1;
      end
    end
    if (!held && clicks != 0) begin
      // the gap end wraps before the compare
      gap_end = release_at + {16'h0, cfg.gap_ms};
      if (gap_end < it.now_ms) begin
        pending = (clicks == 8'd1) ? EV_SINGLE : EV_MULTI;
        if (cfg.report_mode != RPT_NONE) return take_report();
      end
    end
    return snapshot();
  endfunction

  function void note_item(item_t it);
    due_results.push_back(predict_click_result(it));
  endfunction

  function string show(result_t r);
    return $sformatf("pressed=%0b event=%0d clicks=%0d duration=%0d report=%0b",
                     r.is_pressed, r.event_kind, r.click_count, r.duration_ms,
                     r.report_valid);
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_result(result_t got);
    result_t exp;
    if (due_results.size() == 0) begin
      note_failure({"result with nothing outstanding: ", show(got)});
      return;
    end
    exp = due_results.pop_front();
    if (got.is_pressed !== exp.is_pressed || got.event_kind !== exp.event_kind ||
        got.click_count !== exp.click_count || got.duration_ms !== exp.duration_ms ||
        got.report_valid !== exp.report_valid)
      note_failure({"expected ", show(exp), " got ", show(got)});
  endfunction

  function int unsigned outstanding();
    return due_results.size();
  endfunction
endclass

module tb;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldOff    = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmcd_item_if   item_if ();
  bmcd_result_if result_if ();
  bmcd_cfg_if    cfg_if ();

  button_multi_click_detector_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  click_scoreboard sb = new();

  int unsigned      src_idle_pct = 0;
  int unsigned      snk_stall_pct = 0;
  int unsigned      items_sent = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      hold_left = 0;
  bit               hold_off_req = 1'b0;
  logic [TimeW-1:0] ms_now = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    item_if.valid        = 1'b0;
    item_if.opcode       = OP_SAMPLE;
    item_if.button_level = 1'b1;
    item_if.now_ms       = '0;
    result_if.ready      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
  end

  // result side: random stalls plus the occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HoldOff;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.is_pressed   = result_if.is_pressed;
      got.event_kind   = event_e'(result_if.event_kind);
      got.click_count  = result_if.click_count;
      got.duration_ms  = result_if.duration_ms;
      got.report_valid = result_if.report_valid;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) ||
        (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("** button_multi_click_detector_unit: FAILED **");
    $finish;
  end

  task automatic send_item(input op_e op, input logic level, input logic [TimeW-1:0] now);
    item_t it;
    it.opcode       = op;
    it.button_level = level;
    it.now_ms       = now;
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.opcode       <= op;
    item_if.button_level <= level;
    item_if.now_ms       <= now;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic sample(input logic level, input logic [TimeW-1:0] now);
    send_item(OP_SAMPLE, level, now);
  endtask

  task automatic clear_op();
    send_item(OP_CLEAR, 1'($urandom_range(1)), $urandom());
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic auto_rst, input report_e mode,
                            input logic [MsCfgW-1:0] minp, input logic [MsCfgW-1:0] gap);
    settle();
    write_reg(RegAutoReset, {15'h0, auto_rst});
    write_reg(RegReportMode, {14'h0, mode});
    write_reg(RegMinPress, minp);
    write_reg(RegGap, gap);
    cfg_if.valid <= 1'b0;
  endtask

  // one to five presses around the minimum length, then a quiet spell
  task automatic click_burst();
    int unsigned      n_clicks;
    logic [TimeW-1:0] minp;
    logic [TimeW-1:0] gap;
    minp     = {16'h0, sb.cfg.min_press_ms};
    gap      = {16'h0, sb.cfg.gap_ms};
    n_clicks = $urandom_range(1, 5);
    for (int unsigned k = 0; k < n_clicks; k++) begin
      ms_now += $urandom_range(1, 8);
      sample(1'b0, ms_now);
      if ($urandom_range(3) == 0) begin
        ms_now += $urandom_range(0, 3);
        sample(1'b0, ms_now);
      end
      case ($urandom_range(3))
        0: ms_now += minp;
        1: ms_now += minp + 1;
        2: ms_now += $urandom_range(0, minp);
        default: ms_now += minp + 1 + $urandom_range(0, 300);
      endcase
      sample(1'b1, ms_now);
      if (k + 1 < n_clicks && $urandom_range(2) == 0) begin
        ms_now += $urandom_range(0, gap);
        sample(1'b1, ms_now);
      end
    end
    ms_now += gap + $urandom_range(0, 2);
    sample(1'b1, ms_now);
    repeat ($urandom_range(0, 2)) begin
      ms_now += $urandom_range(0, 50);
      sample(1'($urandom_range(1)), ms_now);
    end
  endtask

  task automatic run_segment(input int unsigned src_pct, input int unsigned snk_pct,
                             input logic auto_rst, input report_e mode,
                             input logic [MsCfgW-1:0] minp, input logic [MsCfgW-1:0] gap,
                             input bit squeeze, input int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    set_config(auto_rst, mode, minp, gap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    goal          = items_sent + n_items;
    ms_now = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
    if (squeeze) hold_off_req = 1'b1;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) click_burst();
      else if (pick < 85) send_item(op_e'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
      else clear_op();
      // a standing report only goes away with a clear
      if (sb.cfg.report_mode != RPT_NONE && !sb.cfg.auto_reset && $urandom_range(1) == 1)
        clear_op();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // register defaults: no reporting, 50 ms press, 200 ms gap
    sample(1'b1, 32'd0);
    sample(1'b0, 32'd100);
    sample(1'b0, 32'd120);
    sample(1'b1, 32'd151);
    sample(1'b0, 32'd200);
    sample(1'b1, 32'd250);
    sample(1'b1, 32'd450);
    sample(1'b1, 32'd451);
    sample(1'b0, 32'd500);
    sample(1'b1, 32'd600);
    sample(1'b1, 32'd801);
    clear_op();
    // release near the top of the range, so the gap end wraps
    sample(1'b0, 32'hFFFF_FF00);
    sample(1'b1, 32'hFFFF_FF90);
    sample(1'b0, 32'hFFFF_FFFF);
    sample(1'b1, 32'h0000_0040);
    sample(1'b1, 32'h0000_0200);
    clear_op();

    // report kept standing, then with auto reset
    set_config(1'b0, RPT_BOTH, MinPressReset, GapReset);
    sample(1'b0, 32'd1000);
    sample(1'b1, 32'd1100);
    sample(1'b1, 32'd1301);
    sample(1'b0, 32'd1400);
    clear_op();
    set_config(1'b1, RPT_BOTH, MinPressReset, GapReset);
    sample(1'b0, 32'd10);
    sample(1'b1, 32'd70);
    sample(1'b1, 32'd271);
    sample(1'b1, 32'd300);

    run_segment(0,  0,  1'b0, RPT_NONE,     16'd50,    16'd200,   1'b0, 120);
    run_segment(59, 0,  1'b1, RPT_DURATION, 16'd0,     16'd0,     1'b0, 120);
    run_segment(0,  59, 1'b0, RPT_COUNT,    16'hFFFF,  16'hFFFF,  1'b0, 120);
    run_segment(13, 13, 1'b1, RPT_BOTH,     16'd10,    16'd30,    1'b0, 120);
    run_segment(0,  0,  1'b0, RPT_BOTH,     16'd5,     16'd20,    1'b1, 120);
    run_segment(59, 0,  1'b1, RPT_COUNT,    16'($urandom_range(0, 100)),
                16'($urandom_range(0, 400)), 1'b0, 120);
    run_segment(0,  59, 1'b1, RPT_NONE,     16'hFFFF,  16'd0,     1'b0, 120);
    run_segment(13, 13, 1'b0, RPT_DURATION, 16'($urandom()), 16'($urandom()), 1'b0, 120);

    // enough short presses inside one gap to saturate the click count
    set_config(1'b0, RPT_NONE, 16'd0, 16'hFFFF);
    ms_now = $urandom();
    repeat (280) begin
      ms_now += 1;
      sample(1'b0, ms_now);
      ms_now += 1;
      sample(1'b1, ms_now);
    end
    ms_now += 70000;
    sample(1'b1, ms_now);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("** button_multi_click_detector_unit: PASSED **");
    else
      $display("** button_multi_click_detector_unit: FAILED **");
    $finish;
  end

endmodule
